/* src/sorted_priority_queue_defines.svh */
// Assertion macros for the sorted priority queue.
// Included by the top level only; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define SPQ_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define SPQ_ASSERT_IMP(label, cond, prop)
`define SPQ_ASSERT_NXT(label, cond, prop)
`endif
`endif

/* src/spq_pkg.sv */
// Package of the sorted priority queue: field widths, codes and word types.
// No dependencies; every other file but the assertion macro header uses it by scoped names.
package spq_pkg;

    localparam int DATA_W = 32;
    localparam int PRIO_W = 8;
    localparam int FILL_W = 4;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // A classified request as it waits in the front queue.
    typedef struct packed {
        t_op                       op;
        logic signed [DATA_W-1:0]  data;
        logic        [PRIO_W-1:0]  prio;
    } t_cmd;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  out_data;
        logic        [PRIO_W-1:0]  out_priority;
        logic        [FILL_W-1:0]  fill_level;
    } t_rsp;

endpackage

/* src/spq_if.sv */
// Request and response channel interfaces of the sorted priority queue.
// Depends on spq_pkg for widths and the status code.
interface spq_req_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic signed [spq_pkg::DATA_W-1:0] item_data;
    logic        [spq_pkg::PRIO_W-1:0] item_priority;

    modport source(output valid, output req_type, output item_data, output item_priority,
                   input ready);
    modport sink(input valid, input req_type, input item_data, input item_priority,
                 output ready);
endinterface

interface spq_rsp_if;
    logic                              valid;
    logic                              ready;
    spq_pkg::t_status                  status;
    logic signed [spq_pkg::DATA_W-1:0] out_data;
    logic        [spq_pkg::PRIO_W-1:0] out_priority;
    logic        [spq_pkg::FILL_W-1:0] fill_level;

    modport source(output valid, output status, output out_data, output out_priority,
                   output fill_level, input ready);
    modport sink(input valid, input status, input out_data, input out_priority,
                 input fill_level, output ready);
endinterface

/* src/spq_front.sv */
// Front end: accepts request words, decodes the operation and holds them
// in a two-entry queue. Depends on spq_pkg and spq_req_if.
module spq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spq_req_if.sink       i_req,
    output spq_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_take
);

    spq_pkg::t_cmd r_slot [2];
    logic          r_wr_ptr, n_wr_ptr;
    logic          r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_cnt, n_cnt;
    logic          push;
    logic          pop;
    spq_pkg::t_cmd in_cmd;

    assign i_req.ready = (r_cnt != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign pop         = o_cmd_valid && i_cmd_take;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_slot[r_rd_ptr];

    always_comb begin
        in_cmd.op   = spq_pkg::t_op'(i_req.req_type);
        in_cmd.data = i_req.item_data;
        in_cmd.prio = i_req.item_priority;
    end

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

/* src/spq_back.sv */
// Back end: the sorted row of entry cells, the entry count and the
// response register. Depends on spq_pkg and spq_rsp_if.
module spq_back #(
    parameter int CAPACITY = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  spq_pkg::t_cmd i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_take,
    spq_rsp_if.source     o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic        [spq_pkg::PRIO_W-1:0] r_prio [CAPACITY];
    logic        [spq_pkg::PRIO_W-1:0] n_prio [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] r_data [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] n_data [CAPACITY];
    logic        [CNT_W-1:0]           r_count, n_count;
    spq_pkg::t_rsp                     r_rsp, n_rsp;
    logic                              r_rsp_valid, n_rsp_valid;

    logic [CAPACITY-1:0]               gt;
    logic [CAPACITY-1:0]               gt_prev;
    logic        [spq_pkg::PRIO_W-1:0] prev_prio [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] prev_data [CAPACITY];
    logic        [spq_pkg::PRIO_W-1:0] next_prio [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] next_data [CAPACITY];
    logic                              full;
    logic                              empty;
    logic [CNT_W+spq_pkg::FILL_W-1:0]  fill_ext;

    assign full       = (r_count == CNT_W'(CAPACITY));
    assign empty      = (r_count == '0);
    assign o_cmd_take = i_cmd_valid && (!r_rsp_valid || o_rsp.ready);

    // Each cell compares its own priority against the incoming one; the row
    // is sorted, so the flags form one run from the insert point to the last occupied cell.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            gt[i] = (CNT_W'(i) < r_count) && (r_prio[i] > i_cmd.prio);
        end
        gt_prev      = {gt[CAPACITY-2:0], 1'b0};
        prev_prio[0] = i_cmd.prio;
        prev_data[0] = i_cmd.data;
        for (int i = 1; i < CAPACITY; i++) begin
            prev_prio[i] = r_prio[i-1];
            prev_data[i] = r_data[i-1];
        end
        for (int i = 0; i < CAPACITY - 1; i++) begin
            next_prio[i] = r_prio[i+1];
            next_data[i] = r_data[i+1];
        end
        next_prio[CAPACITY-1] = r_prio[CAPACITY-1];
        next_data[CAPACITY-1] = r_data[CAPACITY-1];
    end

    always_comb begin
        n_prio      = r_prio;
        n_data      = r_data;
        n_count     = r_count;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && !o_rsp.ready;
        fill_ext    = '0;
        if (o_cmd_take) begin
            n_rsp_valid        = 1'b1;
            n_rsp.status       = spq_pkg::ST_DONE;
            n_rsp.out_data     = '0;
            n_rsp.out_priority = '0;
            case (i_cmd.op)
                spq_pkg::OP_INSERT: begin
                    if (full) begin
                        n_rsp.status = spq_pkg::ST_FULL;
                    end else begin
                        // The first free cell takes the last shifted entry when
                        // the run of greater cells reaches it, else the new one.
                        for (int i = 0; i < CAPACITY; i++) begin
                            if (gt[i] || (CNT_W'(i) == r_count)) begin
                                n_prio[i] = gt_prev[i] ? prev_prio[i] : i_cmd.prio;
                                n_data[i] = gt_prev[i] ? prev_data[i] : i_cmd.data;
                            end
                        end
                        n_count = r_count + CNT_W'(1);
                    end
                end
                spq_pkg::OP_REMOVE: begin
                    if (empty) begin
                        n_rsp.status = spq_pkg::ST_EMPTY;
                    end else begin
                        n_rsp.out_data     = r_data[0];
                        n_rsp.out_priority = r_prio[0];
                        n_prio             = next_prio;
                        n_data             = next_data;
                        n_count            = r_count - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
            fill_ext         = {{spq_pkg::FILL_W{1'b0}}, n_count};
            n_rsp.fill_level = fill_ext[spq_pkg::FILL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_data <= n_data;
        r_rsp  <= n_rsp;
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.status       = r_rsp.status;
    assign o_rsp.out_data     = r_rsp.out_data;
    assign o_rsp.out_priority = r_rsp.out_priority;
    assign o_rsp.fill_level   = r_rsp.fill_level;

endmodule

/* src/sorted_priority_queue.sv */
// Sorted priority queue top level: front queue plus sorted cell row.
// A word accepted into the front queue is registered there; the back end then registers
// its response in the response register, where it waits for the sink to take it.
// Throughput: one word per cycle while the sink keeps ready high; each request is
// one parallel update of the cell row, so the rate does not depend on CAPACITY.
// Reset (synchronous, active low) empties the queue and drops pending words.
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue #(
    parameter int CAPACITY = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    // Low bits of the capacity as the fill level reports them when full.
    localparam logic [spq_pkg::FILL_W-1:0] LP_CAP_FILL = CAPACITY[spq_pkg::FILL_W-1:0];

    // Request words handed from the front queue to the back end.
    spq_pkg::t_cmd cmd;
    logic          cmd_valid;
    logic          cmd_take;

    // The front end decodes each request word and parks it in a two-entry
    // queue, so input acceptance continues, until both entries fill, while the back end is
    // stalled by a response that the sink has not yet taken.
    spq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_take  (cmd_take)
    );

    // The back end holds the entries sorted by ascending priority. An insert
    // shifts every entry of greater priority up by one cell, which keeps ties
    // in arrival order; a remove returns cell zero and shifts the rest down.
    // Every request produces one response word in the output register.
    spq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_take  (cmd_take),
        .o_rsp       (o_rsp)
    );

    // A word taken by the back end always leaves a response the next cycle.
    `SPQ_ASSERT_NXT(a_take_gives_rsp, cmd_take, o_rsp.valid)
    // The back end never takes a word the front queue does not hold.
    `SPQ_ASSERT_IMP(a_take_needs_word, cmd_take, cmd_valid)
    // A full response reports the queue at capacity.
    `SPQ_ASSERT_IMP(a_full_level, o_rsp.valid && o_rsp.status == spq_pkg::ST_FULL, o_rsp.fill_level == LP_CAP_FILL)
    // An empty response reports an empty queue and carries no entry.
    `SPQ_ASSERT_IMP(a_empty_zero, o_rsp.valid && o_rsp.status == spq_pkg::ST_EMPTY, o_rsp.fill_level == '0 && o_rsp.out_data == '0)

endmodule

/* sim/tb_sorted_priority_queue.sv */
// Self-checking testbench for the sorted priority queue: accepted request words update
// a software mirror of the queue contents, and response words are checked against it.
// Depends on spq_pkg, the spq_req_if / spq_rsp_if interfaces and the queue top level.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

    localparam int QUEUE_DEPTH = 8;
    // Far beyond the slowest correct run (about 1800 words, each delayed at most by one
    // sender gap, receiver stalls and the queue latency, plus the long hold).
    localparam int TIMEOUT_NS  = 400_000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASES      = 18;
    localparam int PHASE_WORDS = 100;

    // Mirror of the queue contents. Each accepted request updates the mirror and
    // queues the response word that it must produce; responses are checked in order.
    class queue_mirror;
        int                                depth;
        logic signed [spq_pkg::DATA_W-1:0] held_data[$];
        logic        [spq_pkg::PRIO_W-1:0] held_prio[$];
        spq_pkg::t_rsp                     pending_responses[$];
        int                                mismatches;

        function new(int capacity);
            depth      = capacity;
            mismatches = 0;
        endfunction

        function void note_request(spq_pkg::t_op op,
                                   logic signed [spq_pkg::DATA_W-1:0] data,
                                   logic [spq_pkg::PRIO_W-1:0] prio);
            spq_pkg::t_rsp rsp;
            int            pos;
            rsp        = '0;
            rsp.status = spq_pkg::ST_DONE;
            if (op == spq_pkg::OP_INSERT) begin
                if (held_prio.size() >= depth) begin
                    rsp.status = spq_pkg::ST_FULL;
                end else begin
                    // Equal priorities stay in arrival order: skip past them.
                    pos = 0;
                    while (pos < held_prio.size() && held_prio[pos] <= prio)
                        pos++;
                    held_prio.insert(pos, prio);
                    held_data.insert(pos, data);
                end
            end else begin
                if (held_prio.size() == 0) begin
                    rsp.status = spq_pkg::ST_EMPTY;
                end else begin
                    rsp.out_data     = held_data.pop_front();
                    rsp.out_priority = held_prio.pop_front();
                end
            end
            rsp.fill_level = spq_pkg::FILL_W'(held_prio.size());
            pending_responses.push_back(rsp);
        endfunction

        function void report_mismatch(string what, spq_pkg::t_rsp want,
                                      spq_pkg::t_rsp got);
            mismatches++;
            if (mismatches <= 10)
                $display("%t mismatch (%s): want status=%0d data=%0d prio=%0d fill=%0d,",
                         $realtime, what, want.status, want.out_data, want.out_priority,
                         want.fill_level,
                         " got status=%0d data=%0d prio=%0d fill=%0d",
                         got.status, got.out_data, got.out_priority, got.fill_level);
        endfunction

        function void check_response(spq_pkg::t_rsp got);
            spq_pkg::t_rsp want;
            if (pending_responses.size() == 0) begin
                report_mismatch("no request outstanding", '0, got);
                return;
            end
            want = pending_responses.pop_front();
            if (got.status !== want.status || got.out_data !== want.out_data ||
                got.out_priority !== want.out_priority ||
                got.fill_level !== want.fill_level)
                report_mismatch("field", want, got);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    sorted_priority_queue #(
        .CAPACITY (QUEUE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    queue_mirror mirror = new(QUEUE_DEPTH);

    // Knobs shared by the driving processes. The sender changes them per phase.
    bit source_gaps  = 1'b0;  // sender may leave idle bursts between words
    bit sink_stalls  = 1'b0;  // receiver may drop ready in bursts
    bit calm         = 1'b0;  // final stretch: no idling on either side
    bit hold_request = 1'b0;  // asks the receiver for one long hold-off

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Every input is known from time zero; reset is held low from time zero and then released.
    initial begin
        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= spq_pkg::OP_INSERT;
        req_ch.item_data     <= '0;
        req_ch.item_priority <= '0;
        rsp_ch.ready         <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Monitor. Both channels are sampled at the rising edge, where every driven
    // value is still the one from before the edge. The response is handled first,
    // although it can never belong to a request accepted at the same edge.
    always @(posedge i_clk) begin
        spq_pkg::t_rsp seen;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                seen.status       = rsp_ch.status;
                seen.out_data     = rsp_ch.out_data;
                seen.out_priority = rsp_ch.out_priority;
                seen.fill_level   = rsp_ch.fill_level;
                mirror.check_response(seen);
            end
            if (req_ch.valid && req_ch.ready)
                mirror.note_request(spq_pkg::t_op'(req_ch.req_type), req_ch.item_data,
                                    req_ch.item_priority);
        end
    end

    // Receiver. Each pass sets ready for a run of cycles. A hold request from the
    // sender drops ready for a long stretch so that the queue backs up into the
    // request channel while the sender keeps offering words.
    initial begin
        int span;
        @(posedge i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                span = HOLD_CYCLES;
            end else if (!calm && sink_stalls && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                span = $urandom_range(1, 4);
            end else begin
                rsp_ch.ready <= 1'b1;
                span = $urandom_range(1, 6);
            end
            repeat (span) @(posedge i_clk);
        end
    end

    // Offers one request word and returns at the edge that accepts it. Valid stays
    // high on return so that back-to-back words need no second assignment.
    task automatic offer_word(input spq_pkg::t_op op,
                              input logic signed [spq_pkg::DATA_W-1:0] data,
                              input logic [spq_pkg::PRIO_W-1:0] prio);
        if (!calm && source_gaps && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= op;
        req_ch.item_data     <= data;
        req_ch.item_priority <= prio;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Random request. Priorities often fall in narrow bands at either end so that
    // ties are common; data words are mostly uniform with the odd extreme.
    task automatic offer_random(input int insert_pct);
        spq_pkg::t_op                      op;
        logic signed [spq_pkg::DATA_W-1:0] data;
        logic        [spq_pkg::PRIO_W-1:0] prio;
        op = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
        case ($urandom_range(0, 5))
            0:       prio = spq_pkg::PRIO_W'($urandom_range(0, 3));
            1:       prio = spq_pkg::PRIO_W'($urandom_range(252, 255));
            default: prio = spq_pkg::PRIO_W'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 15))
            0:       data = 32'sh7FFF_FFFF;
            1:       data = 32'sh8000_0000;
            default: data = $urandom;
        endcase
        offer_word(op, data, prio);
    endtask

    // Drops valid and waits until every outstanding request has been answered.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (mirror.pending_responses.size() != 0)
            @(posedge i_clk);
    endtask

    // Sender: a directed opening, then phases of random words whose insert
    // ratio swings between filling, draining and balanced traffic.
    initial begin
        int insert_pct;
        @(posedge i_rst_n);
        @(posedge i_clk);

        // Remove from an empty queue, with nonzero fields that must be ignored.
        offer_word(spq_pkg::OP_REMOVE, 32'sh7FFF_FFFF, 8'hFF);
        // Fill to capacity with both priority extremes, ties at each end and in
        // the middle, and both data extremes.
        offer_word(spq_pkg::OP_INSERT, 32'sh7FFF_FFFF, 8'd0);
        offer_word(spq_pkg::OP_INSERT, 32'sh8000_0000, 8'd255);
        offer_word(spq_pkg::OP_INSERT, -32'sd1, 8'd0);
        offer_word(spq_pkg::OP_INSERT, 32'sd0, 8'd128);
        offer_word(spq_pkg::OP_INSERT, 32'sd1, 8'd255);
        offer_word(spq_pkg::OP_INSERT, 32'sh5555_5555, 8'd1);
        offer_word(spq_pkg::OP_INSERT, 32'shAAAA_AAAA, 8'd254);
        offer_word(spq_pkg::OP_INSERT, 32'sd12345, 8'd128);
        // Inserts into a full queue are refused, even one at the lowest priority value.
        offer_word(spq_pkg::OP_INSERT, 32'sd77, 8'd7);
        offer_word(spq_pkg::OP_INSERT, 32'sh8000_0000, 8'd0);
        // Drain everything in priority order, then two removes too many.
        repeat (QUEUE_DEPTH) offer_word(spq_pkg::OP_REMOVE, 32'sh8000_0000, 8'h00);
        offer_word(spq_pkg::OP_REMOVE, -32'sd1, 8'hA5);
        offer_word(spq_pkg::OP_REMOVE, 32'sd0, 8'h5A);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 3)
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                default: insert_pct = 50;
            endcase
            source_gaps = $urandom_range(0, 3) != 0;
            sink_stalls = $urandom_range(0, 3) != 0;
            calm        = phase >= PHASES - 3;
            if (phase == 4) begin
                // Long receiver hold while the sender streams without gaps.
                source_gaps  = 1'b0;
                hold_request = 1'b1;
                insert_pct   = 70;
            end
            if (phase == 7)
                wait_for_drain();
            repeat (PHASE_WORDS) offer_random(insert_pct);
        end

        wait_for_drain();
        repeat (10) @(posedge i_clk);
        if (mirror.mismatches == 0 && mirror.pending_responses.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
